@@ design/sqs_pkg.sv @@
// Shared types and constants for the stack/queue store.
// No dependencies; used by stack_queue_store_core.
package sqs_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		FUNC_PUSH = 2'd0,
		FUNC_POP  = 2'd1,
		FUNC_LIST = 2'd2,
		FUNC_NOP  = 2'd3
	} sqs_func_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RSVD  = 2'd3
	} sqs_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_LIST
	} sqs_state_t;

endpackage

@@ design/stack_queue_store_core.sv @@
// Stack/queue store: one synchronous word memory with low and high pointers.
// Depends on sqs_pkg.
//
// Usage:
//   Input stream (s_*): s_tuser carries the operation (push, pop, list), s_tdata
//   the word to push. Output stream (m_*): m_tuser carries the status, m_tdata the
//   popped or listed word (zero unless status is done), m_tlast marks the final
//   result of an operation. cfg_* writes the mode bit (1 queue, 0 stack).
// Timing:
//   Push and the empty/full answers load the output register in the transfer
//   cycle itself, so a new item can follow at once while the output is free.
//   A pop reads the memory into the read register, and the pop state moves the
//   word to the output register once that is free; the input waits meanwhile.
//   A list reads one entry and emits one result per cycle while the output is
//   not stalled, holding the input to the end; the single read port sets this pace.
//   An unused operation code is taken and produces nothing.
// Reset: pointers clear (store empty), mode returns to queue; memory contents
//   are not cleared and need no sweep.
// Stall: a result waits in the output register while m_tready is low; the
//   input and the list walk hold until the register can be refilled.
module stack_queue_store_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [sqs_pkg::WORD_W-1:0]  s_tdata,  // [31:0] value
	input  logic [1:0]                  s_tuser,  // [1:0] func
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [sqs_pkg::WORD_W-1:0]  m_tdata,  // [31:0] data_out
	output logic [1:0]                  m_tuser,  // [1:0] status
	output logic                        m_tlast,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data
);

	sqs_pkg::sqs_state_t state_q, state_next;

	logic [sqs_pkg::WORD_W-1:0] mem_q [sqs_pkg::DEPTH];
	logic [sqs_pkg::WORD_W-1:0] rd_data_q;

	logic [sqs_pkg::IDX_W-1:0] low_q, high_q, walk_q, cnt_q;
	logic                      mode_q;

	logic                      m_tvalid_q, m_tlast_q;
	logic [sqs_pkg::WORD_W-1:0] m_tdata_q;
	logic [1:0]                m_tuser_q;

	logic                      accept, out_free, empty, full;
	logic                      wr_en, rd_en, out_load, out_last;
	logic [sqs_pkg::ADDR_W-1:0] rd_addr;
	logic [sqs_pkg::IDX_W-1:0] rd_idx, high_m1;
	logic [1:0]                out_status;
	logic [sqs_pkg::WORD_W-1:0] out_data;
	logic                      low_inc, high_inc, high_dec, list_start, walk_step;
	sqs_pkg::sqs_func_t        func;

	assign func     = sqs_pkg::sqs_func_t'(s_tuser);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == sqs_pkg::ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign empty    = low_q >= high_q;
	assign full     = high_q >= sqs_pkg::IDX_W'(sqs_pkg::DEPTH);
	assign high_m1  = high_q - sqs_pkg::IDX_W'(1);
	assign rd_addr  = rd_idx[sqs_pkg::ADDR_W-1:0];
	// a mode write waits while an operation is in progress or an input transfer takes place
	assign cfg_ready = (state_q == sqs_pkg::ST_IDLE) && !accept;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			sqs_pkg::ST_IDLE: begin
				if (accept && !empty) begin
					if (func == sqs_pkg::FUNC_POP) begin
						state_next = sqs_pkg::ST_POP;
					end else if (func == sqs_pkg::FUNC_LIST) begin
						state_next = sqs_pkg::ST_LIST;
					end
				end
			end
			sqs_pkg::ST_POP: begin
				if (out_free) begin
					state_next = sqs_pkg::ST_IDLE;
				end
			end
			sqs_pkg::ST_LIST: begin
				if (out_free && cnt_q == sqs_pkg::IDX_W'(1)) begin
					state_next = sqs_pkg::ST_IDLE;
				end
			end
			default: state_next = sqs_pkg::ST_IDLE;
		endcase
	end

	// control and result selection
	always_comb begin
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_idx     = walk_q;
		out_load   = 1'b0;
		out_last   = 1'b1;
		out_status = sqs_pkg::STAT_DONE;
		out_data   = '0;
		low_inc    = 1'b0;
		high_inc   = 1'b0;
		high_dec   = 1'b0;
		list_start = 1'b0;
		walk_step  = 1'b0;
		case (state_q)
			sqs_pkg::ST_IDLE: begin
				if (accept) begin
					case (func)
						sqs_pkg::FUNC_PUSH: begin
							out_load = 1'b1;
							if (full) begin
								out_status = sqs_pkg::STAT_FULL;
							end else begin
								wr_en    = 1'b1;
								high_inc = 1'b1;
							end
						end
						sqs_pkg::FUNC_POP: begin
							if (empty) begin
								out_load   = 1'b1;
								out_status = sqs_pkg::STAT_EMPTY;
							end else begin
								rd_en    = 1'b1;
								rd_idx   = mode_q ? low_q : high_m1;
								low_inc  = mode_q;
								high_dec = !mode_q;
							end
						end
						sqs_pkg::FUNC_LIST: begin
							if (empty) begin
								out_load   = 1'b1;
								out_status = sqs_pkg::STAT_EMPTY;
							end else begin
								rd_en      = 1'b1;
								rd_idx     = mode_q ? low_q : high_m1;
								list_start = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			sqs_pkg::ST_POP: begin
				if (out_free) begin
					out_load = 1'b1;
					out_data = rd_data_q;
				end
			end
			sqs_pkg::ST_LIST: begin
				if (out_free) begin
					out_load = 1'b1;
					out_data = rd_data_q;
					out_last = (cnt_q == sqs_pkg::IDX_W'(1));
					if (!out_last) begin
						rd_en     = 1'b1;
						walk_step = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// word memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[high_q[sqs_pkg::ADDR_W-1:0]] <= s_tdata;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sqs_pkg::ST_IDLE;
			low_q      <= '0;
			high_q     <= '0;
			walk_q     <= '0;
			cnt_q      <= '0;
			mode_q     <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (low_inc) begin
				low_q <= low_q + sqs_pkg::IDX_W'(1);
			end
			if (high_inc) begin
				high_q <= high_q + sqs_pkg::IDX_W'(1);
			end else if (high_dec) begin
				high_q <= high_m1;
			end
			if (list_start) begin
				cnt_q  <= high_q - low_q;
				walk_q <= mode_q ? low_q + sqs_pkg::IDX_W'(1) : high_m1 - sqs_pkg::IDX_W'(1);
			end else if (walk_step) begin
				cnt_q  <= cnt_q - sqs_pkg::IDX_W'(1);
				walk_q <= mode_q ? walk_q + sqs_pkg::IDX_W'(1) : walk_q - sqs_pkg::IDX_W'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= out_data;
			m_tuser_q <= out_status;
			m_tlast_q <= out_last;
		end
	end

	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= high_q)
		else $error("low pointer passed high pointer");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		high_q <= sqs_pkg::IDX_W'(sqs_pkg::DEPTH))
		else $error("high pointer beyond depth");

	a_list_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sqs_pkg::ST_LIST |-> cnt_q != '0)
		else $error("list walk with zero remaining");

	a_list_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sqs_pkg::ST_LIST && out_load && out_last) |=>
		(state_q == sqs_pkg::ST_IDLE && m_tvalid_q && m_tlast_q))
		else $error("list did not end after last entry");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != sqs_pkg::ST_IDLE |-> !wr_en && !low_inc && !high_inc && !high_dec)
		else $error("pointer or memory update during a read operation");

endmodule
